>>> rtl/wheel_power_limiter_unit_defines.svh
// Assertion helpers for the RTL
`ifndef WHEEL_POWER_LIMITER_UNIT_DEFINES_SVH
`define WHEEL_POWER_LIMITER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WPL_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WPL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wpl_pkg.sv
package wpl_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int VAL_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int WATT_W      = 24;
    localparam int PROD_W      = 2 * VAL_W - 1;
    localparam int SUM_W       = PROD_W + $clog2(WHEEL_COUNT);
    localparam int PA_W        = GAIN_W + SUM_W;
    localparam int A_W         = SUM_W - 4;
    localparam int B_W         = SUM_W - 8;
    localparam int C_W         = A_W + 2;
    localparam int MC_W        = A_W + 1;
    localparam int BB_W        = 2 * B_W;
    localparam int FAC_W       = A_W + MC_W + 2;
    localparam int D_W         = 2 * ((FAC_W + 2) / 2);
    localparam int R_W         = D_W / 2;
    localparam int RM_W        = R_W + 3;
    localparam int DV_W        = A_W + 2;
    localparam int Q_W         = 16;
    localparam int K_W         = Q_W + 1;
    localparam int IDX_W       = 2;
    localparam int CFG_W       = WATT_W;

    localparam logic [K_W-1:0] UNITY_K = K_W'(65536);

    localparam logic [IDX_W-1:0] REG_EFFORT_GAIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_SPEED_GAIN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_POWER_CAP   = 2'd2;
    localparam logic [IDX_W-1:0] REG_BASE_LOSS   = 2'd3;

    localparam logic [GAIN_W-1:0] EFFORT_GAIN_RST = 16'd1638;
    localparam logic [GAIN_W-1:0] SPEED_GAIN_RST  = 16'd2458;
    localparam logic [WATT_W-1:0] POWER_CAP_RST   = 24'd20480;
    localparam logic [WATT_W-1:0] BASE_LOSS_RST   = 24'd0;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_UNITY = 2'd0;
    localparam mode_t MODE_ZERO  = 2'd1;
    localparam mode_t MODE_LIN   = 2'd2;
    localparam mode_t MODE_QUAD  = 2'd3;

    typedef logic [WHEEL_COUNT-1:0][VAL_W-1:0] wheel_vec_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
    } tag_t;

    typedef struct packed {
        logic [A_W-1:0]  a;
        logic [B_W-1:0]  b;
        logic [MC_W-1:0] magc;
        wheel_vec_t      torque;
    } side_t;

endpackage

>>> rtl/wpl_front.sv
module wpl_front
    import wpl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  wheel_vec_t        speed,
    input  wheel_vec_t        torque,
    input  logic [GAIN_W-1:0] effort_gain,
    input  logic [GAIN_W-1:0] speed_gain,
    input  logic [WATT_W-1:0] power_cap,
    input  logic [WATT_W-1:0] base_loss,
    output tag_t              tag_o,
    output logic [D_W-1:0]    d_o,
    output side_t             side_o
);

    wheel_vec_t mag_s, mag_t;

    logic [WHEEL_COUNT-1:0][PROD_W-1:0] tt1_reg, st1_reg, ss1_reg;
    wheel_vec_t trq1_reg, trq2_reg, trq3_reg, trq4_reg, trq5_reg, trq6_reg;
    logic [5:0] valid_reg;

    logic [SUM_W-1:0] sum_tt_next, sum_st_next, sum_ss_next;
    logic [SUM_W-1:0] sum_tt2_reg, sum_st2_reg, sum_ss2_reg;

    logic [PA_W-1:0] pa3_reg, pv3_reg;
    logic [B_W-1:0]  b3_reg;

    logic [C_W-1:0]  c_next;
    logic [A_W-1:0]  a4_reg;
    logic [B_W-1:0]  b4_reg;
    logic [MC_W-1:0] magc4_reg;
    logic            cneg4_reg, cpos4_reg;

    logic [BB_W-1:0]  bb5_reg;
    logic [FAC_W-1:0] fac5_reg;
    mode_t            mode_next, mode5_reg, mode6_reg;
    logic             cpos5_reg;
    logic [A_W-1:0]   a5_reg;
    logic [B_W-1:0]   b5_reg;
    logic [MC_W-1:0]  magc5_reg, magc6_reg;
    logic [A_W-1:0]   a6_reg;
    logic [B_W-1:0]   b6_reg;
    logic [D_W-1:0]   d6_reg;

    always_comb
    begin
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            mag_s[w] = speed[w][VAL_W-1]  ? VAL_W'(-speed[w])  : speed[w];
            mag_t[w] = torque[w][VAL_W-1] ? VAL_W'(-torque[w]) : torque[w];
        end
    end

    always_comb
    begin
        sum_tt_next = '0;
        sum_st_next = '0;
        sum_ss_next = '0;
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            sum_tt_next = sum_tt_next + SUM_W'(tt1_reg[w]);
            sum_st_next = sum_st_next + SUM_W'(st1_reg[w]);
            sum_ss_next = sum_ss_next + SUM_W'(ss1_reg[w]);
        end
    end

    assign c_next = C_W'(pv3_reg[PA_W-1:20]) - C_W'(power_cap) - C_W'(base_loss);

    always_comb
    begin
        if (b4_reg == '0)
        begin
            mode_next = MODE_UNITY;
        end
        else if (a4_reg == '0)
        begin
            mode_next = cneg4_reg ? MODE_LIN : MODE_ZERO;
        end
        else
        begin
            mode_next = MODE_QUAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int w = 0; w < WHEEL_COUNT; w++)
            begin
                tt1_reg[w] <= PROD_W'(32'(mag_t[w]) * 32'(mag_t[w]));
                st1_reg[w] <= PROD_W'(32'(mag_s[w]) * 32'(mag_t[w]));
                ss1_reg[w] <= PROD_W'(32'(mag_s[w]) * 32'(mag_s[w]));
            end
            trq1_reg <= torque;

            sum_tt2_reg <= sum_tt_next;
            sum_st2_reg <= sum_st_next;
            sum_ss2_reg <= sum_ss_next;
            trq2_reg    <= trq1_reg;

            pa3_reg  <= PA_W'(effort_gain) * PA_W'(sum_tt2_reg);
            pv3_reg  <= PA_W'(speed_gain) * PA_W'(sum_ss2_reg);
            b3_reg   <= sum_st2_reg[SUM_W-1:8];
            trq3_reg <= trq2_reg;

            a4_reg    <= pa3_reg[PA_W-1:20];
            b4_reg    <= b3_reg;
            cneg4_reg <= c_next[C_W-1];
            cpos4_reg <= !c_next[C_W-1] && (c_next != '0);
            magc4_reg <= c_next[C_W-1] ? MC_W'(-c_next) : MC_W'(c_next);
            trq4_reg  <= trq3_reg;

            bb5_reg   <= BB_W'(b4_reg) * BB_W'(b4_reg);
            fac5_reg  <= {(FAC_W-2)'(a4_reg) * (FAC_W-2)'(magc4_reg), 2'b00};
            mode5_reg <= mode_next;
            cpos5_reg <= cpos4_reg;
            a5_reg    <= a4_reg;
            b5_reg    <= b4_reg;
            magc5_reg <= magc4_reg;
            trq5_reg  <= trq4_reg;

            if (cpos5_reg)
            begin
                d6_reg <= D_W'(bb5_reg) - D_W'(fac5_reg);
                if ((mode5_reg == MODE_QUAD) && (D_W'(fac5_reg) > D_W'(bb5_reg)))
                begin
                    mode6_reg <= MODE_UNITY;
                end
                else
                begin
                    mode6_reg <= mode5_reg;
                end
            end
            else
            begin
                d6_reg    <= D_W'(bb5_reg) + D_W'(fac5_reg);
                mode6_reg <= mode5_reg;
            end
            a6_reg    <= a5_reg;
            b6_reg    <= b5_reg;
            magc6_reg <= magc5_reg;
            trq6_reg  <= trq5_reg;
        end
    end

    assign tag_o.valid   = valid_reg[5];
    assign tag_o.mode    = mode6_reg;
    assign d_o           = d6_reg;
    assign side_o.a      = a6_reg;
    assign side_o.b      = b6_reg;
    assign side_o.magc   = magc6_reg;
    assign side_o.torque = trq6_reg;

endmodule

>>> rtl/wpl_sqrt.sv
module wpl_sqrt
    import wpl_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  tag_t           tag_i,
    input  logic [D_W-1:0] d_i,
    input  side_t          side_i,
    output tag_t           tag_o,
    output logic [R_W-1:0] r_o,
    output side_t          side_o
);

    // two radicand bits per stage, one root bit per stage
    tag_t            tag_reg  [R_W];
    logic [RM_W-1:0] rem_reg  [R_W];
    logic [R_W-1:0]  root_reg [R_W];
    logic [D_W-1:0]  dsh_reg  [R_W];
    side_t           side_reg [R_W];

    for (genvar i = 0; i < R_W; i++)
    begin : g_stage
        tag_t            tag_prev;
        logic [RM_W-1:0] rem_prev, cur, trial;
        logic [R_W-1:0]  root_prev;
        logic [D_W-1:0]  dsh_prev;
        side_t           side_prev;

        if (i == 0)
        begin : g_first
            assign tag_prev  = tag_i;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign dsh_prev  = d_i;
            assign side_prev = side_i;
        end
        else
        begin : g_next
            assign tag_prev  = tag_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign dsh_prev  = dsh_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign cur   = {rem_prev[RM_W-3:0], dsh_prev[D_W-1 -: 2]};
        assign trial = RM_W'({root_prev, 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i] <= '0;
            end
            else if (en)
            begin
                tag_reg[i] <= tag_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur >= trial)
                begin
                    rem_reg[i]  <= cur - trial;
                    root_reg[i] <= {root_prev[R_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= cur;
                    root_reg[i] <= {root_prev[R_W-2:0], 1'b0};
                end
                dsh_reg[i]  <= dsh_prev << 2;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign tag_o  = tag_reg[R_W-1];
    assign r_o    = root_reg[R_W-1];
    assign side_o = side_reg[R_W-1];

endmodule

>>> rtl/wpl_div.sv
module wpl_div
    import wpl_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  tag_t           tag_i,
    input  logic [R_W-1:0] r_i,
    input  side_t          side_i,
    output tag_t           tag_o,
    output logic [K_W-1:0] k_o,
    output wheel_vec_t     torque_o
);

    logic            r_gt_b;
    logic [R_W-1:0]  num;
    tag_t            tag_next;
    logic [DV_W-1:0] n_next, m_next;

    tag_t            tagp_reg;
    logic [DV_W-1:0] np_reg, mp_reg;
    logic            satp_reg;
    wheel_vec_t      trqp_reg;

    tag_t            tag_reg  [Q_W];
    logic [DV_W-1:0] rem_reg  [Q_W];
    logic [DV_W-1:0] m_reg    [Q_W];
    logic [Q_W-1:0]  q_reg    [Q_W];
    logic            sat_reg  [Q_W];
    wheel_vec_t      trq_reg  [Q_W];

    assign r_gt_b = r_i > R_W'(side_i.b);
    assign num    = r_i - R_W'(side_i.b);

    always_comb
    begin
        tag_next = tag_i;
        if ((tag_i.mode == MODE_QUAD) && !r_gt_b)
        begin
            tag_next.mode = MODE_ZERO;
        end
        if (tag_i.mode == MODE_LIN)
        begin
            n_next = DV_W'(side_i.magc);
            m_next = DV_W'(side_i.b);
        end
        else
        begin
            n_next = DV_W'(num);
            m_next = DV_W'({side_i.a, 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tagp_reg <= '0;
        end
        else if (en)
        begin
            tagp_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            np_reg   <= n_next;
            mp_reg   <= m_next;
            satp_reg <= n_next >= m_next;
            trqp_reg <= side_i.torque;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < Q_W; j++)
    begin : g_stage
        tag_t            tag_prev;
        logic [DV_W-1:0] rem_prev, m_prev, sh;
        logic [Q_W-1:0]  q_prev;
        logic            sat_prev;
        wheel_vec_t      trq_prev;

        if (j == 0)
        begin : g_first
            assign tag_prev = tagp_reg;
            assign rem_prev = np_reg;
            assign m_prev   = mp_reg;
            assign q_prev   = '0;
            assign sat_prev = satp_reg;
            assign trq_prev = trqp_reg;
        end
        else
        begin : g_next
            assign tag_prev = tag_reg[j-1];
            assign rem_prev = rem_reg[j-1];
            assign m_prev   = m_reg[j-1];
            assign q_prev   = q_reg[j-1];
            assign sat_prev = sat_reg[j-1];
            assign trq_prev = trq_reg[j-1];
        end

        assign sh = {rem_prev[DV_W-2:0], 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[j] <= '0;
            end
            else if (en)
            begin
                tag_reg[j] <= tag_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sh >= m_prev)
                begin
                    rem_reg[j] <= sh - m_prev;
                    q_reg[j]   <= {q_prev[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= sh;
                    q_reg[j]   <= {q_prev[Q_W-2:0], 1'b0};
                end
                m_reg[j]   <= m_prev;
                sat_reg[j] <= sat_prev;
                trq_reg[j] <= trq_prev;
            end
        end
    end

    always_comb
    begin
        case (tag_reg[Q_W-1].mode)
            MODE_UNITY: k_o = UNITY_K;
            MODE_ZERO:  k_o = '0;
            default:    k_o = sat_reg[Q_W-1] ? UNITY_K : {1'b0, q_reg[Q_W-1]};
        endcase
    end

    assign tag_o    = tag_reg[Q_W-1];
    assign torque_o = trq_reg[Q_W-1];

endmodule

>>> rtl/wheel_power_limiter_unit.sv
// Pipeline: 6 front stages, 31 square-root stages, 17 divide stages and
// 1 output register between input transaction and result.
// Throughput: one transaction per cycle; the whole pipeline holds while
// the output register is full and not taken.
// Reset (rst_n low, async): all stages empty, configuration registers to their defaults.
`include "wheel_power_limiter_unit_defines.svh"

module wheel_power_limiter_unit
    import wpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  speed_0,
    input  logic signed [15:0]  speed_1,
    input  logic signed [15:0]  speed_2,
    input  logic signed [15:0]  speed_3,
    input  logic signed [15:0]  torque_0,
    input  logic signed [15:0]  torque_1,
    input  logic signed [15:0]  torque_2,
    input  logic signed [15:0]  torque_3,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  drive_0,
    output logic signed [15:0]  drive_1,
    output logic signed [15:0]  drive_2,
    output logic signed [15:0]  drive_3,
    output logic [K_W-1:0]      scale_factor,
    output logic                was_limited,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    logic [GAIN_W-1:0] effort_gain_reg, speed_gain_reg;
    logic [WATT_W-1:0] power_cap_reg, base_loss_reg;

    logic       en;
    wheel_vec_t speed_vec, torque_vec;

    tag_t           front_tag, sqrt_tag, div_tag;
    logic [D_W-1:0] front_d;
    side_t          front_side, sqrt_side;
    logic [R_W-1:0] sqrt_r;
    logic [K_W-1:0] div_k;
    wheel_vec_t     div_trq;

    logic       limited_next;
    wheel_vec_t drive_next;
    wheel_vec_t drive_reg;
    logic [K_W-1:0] scale_reg;
    logic       limited_reg, out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effort_gain_reg <= EFFORT_GAIN_RST;
            speed_gain_reg  <= SPEED_GAIN_RST;
            power_cap_reg   <= POWER_CAP_RST;
            base_loss_reg   <= BASE_LOSS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EFFORT_GAIN: effort_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_SPEED_GAIN:  speed_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_POWER_CAP:   power_cap_reg   <= cfg_data[WATT_W-1:0];
                REG_BASE_LOSS:   base_loss_reg   <= cfg_data[WATT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign speed_vec  = {speed_3, speed_2, speed_1, speed_0};
    assign torque_vec = {torque_3, torque_2, torque_1, torque_0};

    wpl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .speed       (speed_vec),
        .torque      (torque_vec),
        .effort_gain (effort_gain_reg),
        .speed_gain  (speed_gain_reg),
        .power_cap   (power_cap_reg),
        .base_loss   (base_loss_reg),
        .tag_o       (front_tag),
        .d_o         (front_d),
        .side_o      (front_side)
    );

    wpl_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .tag_i  (front_tag),
        .d_i    (front_d),
        .side_i (front_side),
        .tag_o  (sqrt_tag),
        .r_o    (sqrt_r),
        .side_o (sqrt_side)
    );

    wpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tag_i    (sqrt_tag),
        .r_i      (sqrt_r),
        .side_i   (sqrt_side),
        .tag_o    (div_tag),
        .k_o      (div_k),
        .torque_o (div_trq)
    );

    assign limited_next = !div_k[K_W-1];

    always_comb
    begin
        logic [VAL_W-1:0]   mag;
        logic [2*VAL_W:0]   prod;
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            mag  = div_trq[w][VAL_W-1] ? VAL_W'(-div_trq[w]) : div_trq[w];
            prod = (2*VAL_W+1)'(mag) * (2*VAL_W+1)'(div_k);
            if (limited_next)
            begin
                drive_next[w] = div_trq[w][VAL_W-1] ? VAL_W'(-prod[2*VAL_W-1:Q_W])
                                                    : prod[2*VAL_W-1:Q_W];
            end
            else
            begin
                drive_next[w] = div_trq[w];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drive_reg   <= drive_next;
            scale_reg   <= div_k;
            limited_reg <= limited_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_0      = drive_reg[0];
    assign drive_1      = drive_reg[1];
    assign drive_2      = drive_reg[2];
    assign drive_3      = drive_reg[3];
    assign scale_factor = scale_reg;
    assign was_limited  = limited_reg;

    `WPL_ASSERT_SAME(a_flag_matches_k, out_valid, was_limited == !scale_factor[K_W-1], "limit flag disagrees with scale")
    `WPL_ASSERT_SAME(a_k_in_range, out_valid, !(scale_factor[K_W-1] && (scale_factor[Q_W-1:0] != '0)), "scale above unity")
    `WPL_ASSERT_SAME(a_zero_scale, out_valid && (scale_factor == '0), (drive_0 == '0) && (drive_1 == '0) && (drive_2 == '0) && (drive_3 == '0), "zero scale with nonzero drive")
    `WPL_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

>>> dv/wheel_power_limiter_checker.sv
module wheel_power_limiter_checker
    import wpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic signed [15:0]  speed_0,
    input  logic signed [15:0]  speed_1,
    input  logic signed [15:0]  speed_2,
    input  logic signed [15:0]  speed_3,
    input  logic signed [15:0]  torque_0,
    input  logic signed [15:0]  torque_1,
    input  logic signed [15:0]  torque_2,
    input  logic signed [15:0]  torque_3,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [15:0]  drive_0,
    input  logic signed [15:0]  drive_1,
    input  logic signed [15:0]  drive_2,
    input  logic signed [15:0]  drive_3,
    input  logic [K_W-1:0]      scale_factor,
    input  logic                was_limited,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [3:0][15:0] drv;
        logic [16:0]      k;
        logic             lim;
    } limit_result_t;

    logic [15:0] gain_effort;
    logic [15:0] gain_speed;
    logic [23:0] cap_watts;
    logic [23:0] loss_watts;
    limit_result_t expected_q[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] d);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > d)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (d >= res + bitv)
            begin
                d = d - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] scale_of(input logic [63:0] a, input logic [63:0] b,
                                            input longint c);
        logic [63:0] k;
        logic [63:0] magc;
        logic [63:0] bb;
        logic [63:0] fac;
        logic [63:0] d;
        logic [63:0] r;
        magc = (c < 0) ? 64'(-c) : 64'(c);
        if (b == 0)
            return 64'd65536;
        if (a == 0)
        begin
            if (c >= 0)
                return 0;
            k = (magc << 16) / b;
            return (k >= 65536) ? 64'd65536 : k;
        end
        bb = b * b;
        fac = 4 * a * magc;
        if (c <= 0)
            d = bb + fac;
        else
        begin
            if (fac > bb)
                return 64'd65536;
            d = bb - fac;
        end
        r = int_sqrt(d);
        if (r <= b)
            return 0;
        k = ((r - b) << 16) / (2 * a);
        return (k >= 65536) ? 64'd65536 : k;
    endfunction

    function automatic limit_result_t limit_efforts(input logic signed [3:0][15:0] spd,
                                                    input logic signed [3:0][15:0] trq);
        limit_result_t res;
        logic [63:0] stt;
        logic [63:0] sst;
        logic [63:0] sss;
        logic [63:0] ms;
        logic [63:0] mt;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] v;
        logic [63:0] k;
        logic [63:0] m;
        longint c;
        stt = 0;
        sst = 0;
        sss = 0;
        for (int i = 0; i < 4; i++)
        begin
            ms = (spd[i][15]) ? 64'(-longint'(signed'(spd[i]))) : 64'(spd[i]);
            mt = (trq[i][15]) ? 64'(-longint'(signed'(trq[i]))) : 64'(trq[i]);
            stt += mt * mt;
            sst += ms * mt;
            sss += ms * ms;
        end
        a = (64'(gain_effort) * stt) >> 20;
        b = sst >> 8;
        v = (64'(gain_speed) * sss) >> 20;
        c = longint'(v) - longint'(cap_watts) - longint'(loss_watts);
        k = scale_of(a, b, c);
        res.lim = (k < 65536);
        res.k = k[16:0];
        for (int i = 0; i < 4; i++)
        begin
            if (res.lim)
            begin
                mt = (trq[i][15]) ? 64'(-longint'(signed'(trq[i]))) : 64'(trq[i]);
                m = (mt * k) >> 16;
                res.drv[i] = trq[i][15] ? 16'(-m) : 16'(m);
            end
            else
                res.drv[i] = trq[i];
        end
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        limit_result_t exp_r;
        limit_result_t got;
        if (!rst_n)
        begin
            gain_effort <= EFFORT_GAIN_RST;
            gain_speed  <= SPEED_GAIN_RST;
            cap_watts   <= POWER_CAP_RST;
            loss_watts  <= BASE_LOSS_RST;
            fail_count  <= 0;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(limit_efforts({speed_3, speed_2, speed_1, speed_0},
                                                   {torque_3, torque_2, torque_1, torque_0}));
            if (out_valid && out_ready)
            begin
                got.drv = {drive_3, drive_2, drive_1, drive_0};
                got.k = scale_factor;
                got.lim = was_limited;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction k=%0d", $time, scale_factor);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r != got)
                    begin
                        $display("%0t: mismatch expected drv=%h k=%0d lim=%0b actual drv=%h k=%0d lim=%0b",
                                 $time, exp_r.drv, exp_r.k, exp_r.lim, got.drv, got.k, got.lim);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EFFORT_GAIN: gain_effort <= cfg_data[15:0];
                    REG_SPEED_GAIN:  gain_speed  <= cfg_data[15:0];
                    REG_POWER_CAP:   cap_watts   <= cfg_data;
                    REG_BASE_LOSS:   loss_watts  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> dv/tb_wheel_power_limiter_unit.sv
module tb_wheel_power_limiter_unit;
    import wpl_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [15:0] speed_0 = 0, speed_1 = 0, speed_2 = 0, speed_3 = 0;
    logic signed [15:0] torque_0 = 0, torque_1 = 0, torque_2 = 0, torque_3 = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [15:0] drive_0, drive_1, drive_2, drive_3;
    logic [K_W-1:0]     scale_factor;
    logic               was_limited;
    logic               cfg_we = 0;
    logic [IDX_W-1:0]   cfg_index = REG_EFFORT_GAIN;
    logic [CFG_W-1:0]   cfg_data = 0;
    int                 fail_count;
    int                 pending;
    int                 send_idle = 0;
    int                 recv_stall = 0;

    always #1 clk = ~clk;

    wheel_power_limiter_unit uut (.*);
    wheel_power_limiter_checker chk (.*);

    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    task automatic send_sample(input logic [15:0] s0, s1, s2, s3, t0, t1, t2, t3);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        speed_0 <= s0; speed_1 <= s1; speed_2 <= s2; speed_3 <= s3;
        torque_0 <= t0; torque_1 <= t1; torque_2 <= t2; torque_3 <= t3;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_val(input int span);
        int v;
        v = $urandom_range(2 * span) - span;
        return 16'(v);
    endfunction

    task automatic random_burst(input int n);
        int span;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: span = 32767;
                1: span = 4096;
                2: span = 1024;
                default: span = 256;
            endcase
            if ($urandom_range(9) == 0)
                send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_sample(rand_val(span), rand_val(span), rand_val(span), rand_val(span),
                            rand_val(span), rand_val(span), rand_val(span), rand_val(span));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // zero, extremes, sign mix, small and mid loads
        send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                    16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                    16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'h7fff, 16'h8000, 16'h1000, 16'hf000);
        send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 16'd256);
        send_sample(16'd2560, -16'sd2560, 16'd2560, -16'sd2560,
                    16'd1024, -16'sd1024, 16'd512, -16'sd512);
        send_sample(16'd5120, 16'd5120, 16'd5120, 16'd5120,
                    16'd2560, 16'd2560, 16'd2560, 16'd2560);
        send_sample(16'hffff, 16'd1, 16'hffff, 16'd1, 16'd1, 16'hffff, 16'd1, 16'hffff);
        send_sample(16'd300, 16'd0, 16'd0, 16'd0, 16'd300, 16'd0, 16'd0, 16'd0);
        drain();
        // linear case: zero effort gain
        write_reg(REG_EFFORT_GAIN, '0);
        send_sample(16'd2560, 16'd2560, 16'd2560, 16'd2560,
                    16'd1024, 16'd1024, 16'd1024, 16'd1024);
        send_sample(16'd10, 16'd10, 16'd10, 16'd10, 16'd10, 16'd10, 16'd10, 16'd10);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd100, 16'd100, 16'd100, 16'd100);
        drain();
        // negative discriminant: big speed gain, zero cap
        write_reg(REG_EFFORT_GAIN, 24'hffff);
        write_reg(REG_SPEED_GAIN, 24'hffff);
        write_reg(REG_POWER_CAP, '0);
        write_reg(REG_BASE_LOSS, '0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd10, 16'd10, 16'd10, 16'd10);
        send_sample(16'd4096, 16'd4096, 16'd4096, 16'd4096,
                    16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_sample(16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100);
        drain();
        write_reg(REG_SPEED_GAIN, '0);
        write_reg(REG_POWER_CAP, 24'hffffff);
        write_reg(REG_BASE_LOSS, 24'hffffff);
        send_sample(16'd2560, 16'd2560, 16'd2560, 16'd2560,
                    16'd2560, 16'd2560, 16'd2560, 16'd2560);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 61; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 61; end
                default: begin send_idle = 16; recv_stall = 16; end
            endcase
            case (ph)
                0: begin
                    write_reg(REG_EFFORT_GAIN, CFG_W'(EFFORT_GAIN_RST));
                    write_reg(REG_SPEED_GAIN, CFG_W'(SPEED_GAIN_RST));
                    write_reg(REG_POWER_CAP, POWER_CAP_RST);
                    write_reg(REG_BASE_LOSS, BASE_LOSS_RST);
                end
                default: begin
                    write_reg(REG_EFFORT_GAIN,
                              CFG_W'(($urandom_range(3) == 0) ? 0 : $urandom_range(8000)));
                    write_reg(REG_SPEED_GAIN, CFG_W'($urandom_range(65535)));
                    write_reg(REG_POWER_CAP,
                              CFG_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(100000)));
                    write_reg(REG_BASE_LOSS, CFG_W'($urandom_range(1) ? 0 : $urandom));
                end
            endcase
            random_burst(100);
            drain();
        end
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/wpl_pkg.sv
rtl/wpl_front.sv
rtl/wpl_sqrt.sv
rtl/wpl_div.sv
rtl/wheel_power_limiter_unit.sv
dv/wheel_power_limiter_checker.sv
dv/tb_wheel_power_limiter_unit.sv
